// ===== rtl/escc_pkg.sv =====
// Package for the epoch seconds calendar converter: constants and tables.
`timescale 1ns / 1ps
package escc_pkg;
	localparam int unsigned SEC_PER_DAY = 86400;
	localparam int unsigned SEC_PER_HOUR = 3600;
	localparam int unsigned HOURS_PER_4Y = 1461 * 24;
	localparam int unsigned EPOCH_YEAR = 1970;
	localparam int unsigned LATE_LIMIT = 32'd4107715199;
	localparam int unsigned LATEST_YEAR = 2100;
	localparam int unsigned IN_W = 72;
	localparam int unsigned OUT_W = 72;
	localparam logic FUNC_TO_SECONDS = 1'b0;
	localparam logic FUNC_TO_DATE = 1'b1;

	function automatic logic [4:0] month_len(input logic [3:0] m);
		case (m)
			4'd2: month_len = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
			default: month_len = 5'd31;
		endcase
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		case (m)
			4'd2: days_before = 9'd31;
			4'd3: days_before = 9'd59;
			4'd4: days_before = 9'd90;
			4'd5: days_before = 9'd120;
			4'd6: days_before = 9'd151;
			4'd7: days_before = 9'd181;
			4'd8: days_before = 9'd212;
			4'd9: days_before = 9'd243;
			4'd10: days_before = 9'd273;
			4'd11: days_before = 9'd304;
			4'd12: days_before = 9'd334;
			default: days_before = 9'd0;
		endcase
	endfunction

	// floor(v / 100) for a 12-bit value by reciprocal multiplication
	function automatic logic [5:0] div100(input logic [11:0] v);
		logic [24:0] prod;
		prod = 25'(v) * 25'd5243;
		div100 = prod[24:19];
	endfunction

	// Gregorian leap test, 12-bit year; divisible by 400 = divisible by 100 with quotient % 4 == 0
	function automatic logic greg_leap(input logic [11:0] y);
		logic [5:0] q;
		logic [11:0] r;
		q = div100(y);
		r = y - 12'(q) * 12'd100;
		greg_leap = (y[1:0] == 2'd0) && ((r != 12'd0) || (q[1:0] == 2'd0));
	endfunction

	function automatic logic [9:0] leaps_before(input logic [11:0] y);
		logic [11:0] p;
		logic [5:0] q;
		p = (y == 12'd0) ? 12'd0 : y - 12'd1;
		q = div100(p);
		leaps_before = 10'(p >> 2) - 10'(q) + 10'(q >> 2);
	endfunction
endpackage

// ===== rtl/epoch_seconds_calendar_converter.sv =====
// Top level: pipelined date/seconds converter in both directions.
//
// channel  dir  handshake          payload
// s_axis   in   s_tvalid/tready    func in tuser, date/seconds fields in tdata
// m_axis   out  m_tvalid/tready    result fields in tdata
//
// Five register stages; one transaction can enter every cycle unless the output
// stalls. The result is offered from the stage 5 register; the constant
// divisions are reciprocal multiplies spread over the stages.
// Reset clears only the stage valid bits. A stall at the output holds each full
// stage with no empty stage below it; an empty stage keeps moving.
`timescale 1ns / 1ps
module epoch_seconds_calendar_converter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// seconds_in, year_in, month_in, day_in, hour_in, minute_in, second_in
	input  logic [escc_pkg::IN_W-1:0]    s_tdata,
	input  logic                         s_tuser,   // func
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// seconds_out, year_out, month_out, day_out, hour_out, minute_out, second_out
	output logic [escc_pkg::OUT_W-1:0]   m_tdata,
	output logic                         m_tuser    // date_legal
);
	import escc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	assign en5 = !v_s5 || m_tready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	logic [31:0] sec_i;
	logic [11:0] yr_i;
	logic [3:0] mo_i;
	logic [4:0] dy_i, hr_i;
	logic [5:0] mi_i, se_i;
	assign sec_i = s_tdata[31:0];
	assign yr_i = s_tdata[43:32];
	assign mo_i = s_tdata[47:44];
	assign dy_i = s_tdata[52:48];
	assign hr_i = s_tdata[57:53];
	assign mi_i = s_tdata[63:58];
	assign se_i = s_tdata[69:64];

	// stage 1: mode 0 day count parts, legality; mode 1 seconds to minutes
	logic f_s1, ok_s1, legal_s1;
	logic [19:0] days_s1;
	logic [16:0] hms_s1;
	logic [26:0] t60_s1;
	logic [5:0] sl_s1;

	logic lp;
	logic [4:0] lim;
	logic [61:0] t60_p;
	logic [26:0] t60;
	assign lp = greg_leap(yr_i);
	assign lim = (mo_i == 4'd2) ? (lp ? 5'd29 : 5'd28) : month_len(mo_i);
	// seconds / 60 as (seconds / 4) / 15
	assign t60_p = 62'(sec_i[31:2]) * 62'(32'h8888_8889);
	assign t60 = t60_p[61:35];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en1) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en1) begin
			f_s1 <= s_tuser;
			ok_s1 <= dy_i != 0 && mo_i != 0 && mo_i <= 4'd12 && yr_i >= 12'(EPOCH_YEAR);
			legal_s1 <= !(yr_i < 12'(EPOCH_YEAR) || yr_i > 12'(LATEST_YEAR) || mo_i == 0 ||
				mo_i > 4'd12 || dy_i == 0 || hr_i > 5'd24 || mi_i > 6'd59 || se_i > 6'd59)
				&& dy_i <= lim;
			days_s1 <= 20'(yr_i - 12'(EPOCH_YEAR)) * 20'd365
				+ 20'(leaps_before(yr_i) - leaps_before(12'(EPOCH_YEAR)))
				+ 20'(days_before(mo_i)) + ((mo_i > 4'd2 && lp) ? 20'd1 : 20'd0)
				+ 20'(dy_i) - 20'd1;
			hms_s1 <= 17'(hr_i) * 17'(SEC_PER_HOUR) + 17'(mi_i) * 17'd60 + 17'(se_i);
			t60_s1 <= t60;
			sl_s1 <= sec_i[5:0];
		end
	end

	// stage 2: total seconds (mode 0); hours and 4-year block count (mode 1)
	logic f_s2, ok_s2, legal_s2;
	logic [31:0] tot_s2;
	logic [20:0] hours_s2;
	logic [5:0] q4_s2;
	logic [5:0] se_s2, mi_s2;
	logic [55:0] hr_p;
	logic [20:0] hours;
	logic [43:0] q4_p;
	// minutes / 60 as (minutes / 4) / 15
	assign hr_p = 56'(t60_s1[26:2]) * 56'(32'h8888_8889);
	assign hours = hr_p[55:35];
	// minutes / (60 * 35064) as (minutes / 32) / 65745
	assign q4_p = 44'(t60_s1[26:5]) * 44'd4180971;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en2) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en2) begin
			f_s2 <= f_s1; ok_s2 <= ok_s1; legal_s2 <= legal_s1;
			tot_s2 <= 32'(days_s1) * 32'(SEC_PER_DAY) + 32'(hms_s1);
			hours_s2 <= hours;
			q4_s2 <= q4_p[43:38];
			se_s2 <= sl_s1 - t60_s1[5:0] * 6'd60;
			mi_s2 <= t60_s1[5:0] - hours[5:0] * 6'd60;
		end
	end

	// stage 3: zeroing of bad dates, late fixup; year within block
	logic f_s3, legal_s3;
	logic [31:0] tot_s3;
	logic [11:0] yr_s3;
	logic [15:0] rem_s3;
	logic [5:0] se_s3, mi_s3;
	logic [15:0] rem;
	logic [11:0] y;
	logic [15:0] r;
	assign rem = 16'(hours_s2 - 21'(q4_s2) * 21'(HOURS_PER_4Y));
	// blocks start two years after a leap year, so only the third year is leap
	always_comb begin
		y = 12'(EPOCH_YEAR) + {4'd0, q4_s2, 2'd0};
		r = rem;
		if (r >= 16'd26304) begin
			r = r - 16'd26304;
			y = y + 12'd3;
		end else if (r >= 16'd17520) begin
			r = r - 16'd17520;
			y = y + 12'd2;
		end else if (r >= 16'd8760) begin
			r = r - 16'd8760;
			y = y + 12'd1;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en3) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en3) begin
			f_s3 <= f_s2; legal_s3 <= legal_s2;
			if (!ok_s2) tot_s3 <= 32'd0;
			else if (tot_s2 > 32'(LATE_LIMIT)) tot_s3 <= tot_s2 + 32'(SEC_PER_DAY);
			else tot_s3 <= tot_s2;
			yr_s3 <= y; rem_s3 <= r;
			se_s3 <= se_s2; mi_s3 <= mi_s2;
		end
	end

	// stage 4: hour and day of year
	logic f_s4, legal_s4;
	logic [31:0] tot_s4;
	logic [11:0] yr_s4;
	logic [8:0] doy_s4;
	logic [4:0] hr_s4;
	logic [5:0] se_s4, mi_s4;
	logic [19:0] dq_p;
	logic [8:0] dq;
	// hours / 24 as (hours / 8) / 3
	assign dq_p = 20'(rem_s3[15:3]) * 20'd683;
	assign dq = dq_p[19:11];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en4) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en4) begin
			f_s4 <= f_s3; legal_s4 <= legal_s3; tot_s4 <= tot_s3;
			yr_s4 <= yr_s3;
			hr_s4 <= 5'(rem_s3 - 16'(dq) * 16'd24);
			doy_s4 <= dq + 9'd1;
			se_s4 <= se_s3; mi_s4 <= mi_s3;
		end
	end

	// stage 5: month and day; result select by mode
	logic [OUT_W-1:0] od_s5;
	logic legal_s5;
	logic [8:0] d;
	logic [3:0] mo;
	logic [4:0] dd;
	always_comb begin
		d = doy_s4;
		mo = 4'd1;
		if (yr_s4[1:0] == 2'd0 && d > 9'd60) d = d - 9'd1;
		for (int m = 1; m <= 12; m++) begin
			if (d > days_before(4'(m))) begin
				mo = 4'(m);
			end
		end
		dd = 5'(d - days_before(mo));
		if (yr_s4[1:0] == 2'd0 && doy_s4 == 9'd60) begin
			mo = 4'd2; dd = 5'd29;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en5) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en5) begin
			if (f_s4 == FUNC_TO_SECONDS) begin
				od_s5 <= {OUT_W'(0)} | OUT_W'(tot_s4);
				legal_s5 <= legal_s4;
			end else begin
				od_s5 <= {2'd0, se_s4, mi_s4, hr_s4, dd, mo, yr_s4, 32'd0};
				legal_s5 <= 1'b0;
			end
		end
	end
	assign m_tvalid = v_s5;
	assign m_tdata = od_s5;
	assign m_tuser = legal_s5;
endmodule
